@@ sv/tlctt_pkg.sv @@
// shared types and constants for the two-level cache tag tracker
// no dependencies; used by tlctt_front, tlctt_back and the top level
`timescale 1ns / 1ps

package tlctt_pkg;

   localparam int ADDR_BITS        = 32;
   localparam int LINE_OFFSET_BITS = 6;
   localparam int SET_INDEX_BITS   = 14;
   localparam int TAG_LSB          = LINE_OFFSET_BITS + SET_INDEX_BITS;
   localparam int TAG_BITS         = ADDR_BITS - TAG_LSB;
   localparam int SET_COUNT        = 1 << SET_INDEX_BITS;
   localparam int L1_WAYS          = 2;
   localparam int L2_WAYS          = 4;
   localparam int L1_IDX_BITS      = $clog2(L1_WAYS);
   localparam int L2_IDX_BITS      = $clog2(L2_WAYS);
   localparam int COUNT_BITS       = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QIDX_BITS        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

   typedef logic [SET_INDEX_BITS-1:0] set_idx_type;
   typedef logic [TAG_BITS-1:0]       tag_type;
   typedef logic [COUNT_BITS-1:0]     count_type;

   // one classified reference waiting for the back end
   typedef struct packed {
      set_idx_type set_idx;
      tag_type     tag;
   } tlctt_item_type;

   // everything kept for one set, one memory word
   typedef struct packed {
      logic [L1_WAYS-1:0]               l1_valid;
      logic [L1_WAYS-1:0][TAG_BITS-1:0] l1_tag;
      logic [L1_IDX_BITS-1:0]           l1_victim;
      logic [L2_WAYS-1:0]               l2_valid;
      logic [L2_WAYS-1:0][TAG_BITS-1:0] l2_tag;
      logic [L2_IDX_BITS-1:0]           l2_victim;
   } tlctt_set_type;

   typedef struct packed {
      logic      l1_hit;
      logic      l2_hit;
      count_type l1_miss_total;
      count_type l2_miss_total;
      count_type reference_total;
   } tlctt_result_type;

   // back end to front end
   typedef struct packed {
      logic pop;
      logic clearing;
   } tlctt_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_LOOKUP
   } tlctt_state_type;

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == '1) ? v : v + count_type'(1);
   endfunction

endpackage

@@ sv/tlctt_front.sv @@
// front end: takes addresses, splits them into set index and tag, queues them
// depends on tlctt_pkg
`timescale 1ns / 1ps

module tlctt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_address,
   input  tlctt_pkg::tlctt_status_type status,
   output logic                       q_valid,
   output tlctt_pkg::tlctt_item_type  q_item
);

   tlctt_pkg::tlctt_item_type            entry_ff [tlctt_pkg::QUEUE_DEPTH];
   logic [tlctt_pkg::QIDX_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tlctt_pkg::QIDX_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tlctt_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   tlctt_pkg::tlctt_item_type            new_item;
   logic                                 push;
   logic                                 pop;

   assign new_item.set_idx = req_address[tlctt_pkg::TAG_LSB-1:tlctt_pkg::LINE_OFFSET_BITS];
   assign new_item.tag     = req_address[tlctt_pkg::ADDR_BITS-1:tlctt_pkg::TAG_LSB];

   // no intake while the set memory is being swept after reset
   assign req_ready = (count_ff != tlctt_pkg::QCNT_BITS'(tlctt_pkg::QUEUE_DEPTH))
                      && !status.clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = status.pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tlctt_pkg::QIDX_BITS'(tlctt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + tlctt_pkg::QIDX_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tlctt_pkg::QIDX_BITS'(tlctt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + tlctt_pkg::QIDX_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + tlctt_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tlctt_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ sv/tlctt_back.sv @@
// back end: set memory sweep, read-modify-write of one set per item, counters,
// result register; depends on tlctt_pkg
`timescale 1ns / 1ps

module tlctt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  tlctt_pkg::tlctt_item_type   q_item,
   output tlctt_pkg::tlctt_status_type status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tlctt_pkg::tlctt_result_type rsp_result
);

   tlctt_pkg::tlctt_set_type set_mem [tlctt_pkg::SET_COUNT];

   tlctt_pkg::tlctt_state_type  state_ff, state_in;
   tlctt_pkg::set_idx_type      clear_idx_ff, clear_idx_in;
   tlctt_pkg::tlctt_item_type   cur_ff;
   tlctt_pkg::tlctt_set_type    rd_data_ff;
   tlctt_pkg::count_type        l1_miss_ff, l1_miss_in;
   tlctt_pkg::count_type        l2_miss_ff, l2_miss_in;
   tlctt_pkg::count_type        ref_ff, ref_in;
   logic                        out_valid_ff, out_valid_in;
   tlctt_pkg::tlctt_result_type out_ff;

   logic                        mem_we;
   tlctt_pkg::set_idx_type      mem_waddr;
   tlctt_pkg::tlctt_set_type    mem_wdata;
   logic                        mem_re;
   logic                        fetch_fire;
   logic                        lookup_fire;

   // lookup datapath
   tlctt_pkg::tlctt_set_type             set_new;
   logic                                 l1_hit;
   logic [tlctt_pkg::L1_IDX_BITS-1:0]    l1_way;
   logic                                 l2_hit;
   logic [tlctt_pkg::L2_IDX_BITS-1:0]    l2_way;
   logic                                 l2_free;
   logic [tlctt_pkg::L2_IDX_BITS-1:0]    l2_free_way;
   logic [tlctt_pkg::L2_IDX_BITS-1:0]    v2;
   logic [tlctt_pkg::L1_IDX_BITS-1:0]    v1;

   assign fetch_fire  = (state_ff == tlctt_pkg::ST_FETCH) && q_valid;
   assign lookup_fire = (state_ff == tlctt_pkg::ST_LOOKUP) && (!out_valid_ff || rsp_ready);

   always_comb begin
      l1_hit = 1'b0;
      l1_way = '0;
      for (int w = tlctt_pkg::L1_WAYS - 1; w >= 0; w--) begin
         if (rd_data_ff.l1_valid[w] && (rd_data_ff.l1_tag[w] == cur_ff.tag)) begin
            l1_hit = 1'b1;
            l1_way = tlctt_pkg::L1_IDX_BITS'(w);
         end
      end
      l2_hit = 1'b0;
      l2_way = '0;
      l2_free = 1'b0;
      l2_free_way = '0;
      for (int w = tlctt_pkg::L2_WAYS - 1; w >= 0; w--) begin
         if (rd_data_ff.l2_valid[w] && (rd_data_ff.l2_tag[w] == cur_ff.tag)) begin
            l2_hit = 1'b1;
            l2_way = tlctt_pkg::L2_IDX_BITS'(w);
         end
         if (!rd_data_ff.l2_valid[w]) begin
            l2_free = 1'b1;
            l2_free_way = tlctt_pkg::L2_IDX_BITS'(w);
         end
      end

      v1 = rd_data_ff.l1_victim;

      // l2 victim on a double miss: first free way, else the way that
      // holds the tag about to leave l1 (last such way), else the pointer
      v2 = rd_data_ff.l2_victim;
      if (l2_free) begin
         v2 = l2_free_way;
      end else if (rd_data_ff.l1_valid[v1]) begin
         for (int w = 0; w < tlctt_pkg::L2_WAYS; w++) begin
            if (rd_data_ff.l2_tag[w] == rd_data_ff.l1_tag[v1]) begin
               v2 = tlctt_pkg::L2_IDX_BITS'(w);
            end
         end
      end

      set_new = rd_data_ff;
      if (l1_hit) begin
         if (rd_data_ff.l1_victim == l1_way) begin
            set_new.l1_victim = rd_data_ff.l1_victim + tlctt_pkg::L1_IDX_BITS'(1);
         end
      end else begin
         if (l2_hit) begin
            if (rd_data_ff.l2_victim == l2_way) begin
               set_new.l2_victim = rd_data_ff.l2_victim + tlctt_pkg::L2_IDX_BITS'(1);
            end
         end else begin
            set_new.l2_tag[v2]   = cur_ff.tag;
            set_new.l2_valid[v2] = 1'b1;
            set_new.l2_victim    = v2 + tlctt_pkg::L2_IDX_BITS'(1);
         end
         set_new.l1_tag[v1]   = cur_ff.tag;
         set_new.l1_valid[v1] = 1'b1;
         set_new.l1_victim    = v1 + tlctt_pkg::L1_IDX_BITS'(1);
      end
   end

   always_comb begin
      l1_miss_in = l1_miss_ff;
      l2_miss_in = l2_miss_ff;
      ref_in     = ref_ff;
      if (lookup_fire) begin
         ref_in = tlctt_pkg::sat_inc(ref_ff);
         if (!l1_hit) begin
            l1_miss_in = tlctt_pkg::sat_inc(l1_miss_ff);
            if (!l2_hit) begin
               l2_miss_in = tlctt_pkg::sat_inc(l2_miss_ff);
            end
         end
      end
      out_valid_in = out_valid_ff;
      if (lookup_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      case (state_ff)
         tlctt_pkg::ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + tlctt_pkg::SET_INDEX_BITS'(1);
            if (clear_idx_ff == '1) begin
               state_in = tlctt_pkg::ST_FETCH;
            end
         end
         tlctt_pkg::ST_FETCH: begin
            if (q_valid) begin
               state_in = tlctt_pkg::ST_LOOKUP;
            end
         end
         tlctt_pkg::ST_LOOKUP: begin
            if (lookup_fire) begin
               state_in = tlctt_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = tlctt_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mem_we          = 1'b0;
      mem_waddr       = cur_ff.set_idx;
      mem_wdata       = set_new;
      mem_re          = 1'b0;
      status.pop      = 1'b0;
      status.clearing = 1'b0;
      case (state_ff)
         tlctt_pkg::ST_CLEAR: begin
            mem_we          = 1'b1;
            mem_waddr       = clear_idx_ff;
            mem_wdata       = '0;
            status.clearing = 1'b1;
         end
         tlctt_pkg::ST_FETCH: begin
            mem_re     = q_valid;
            status.pop = q_valid;
         end
         tlctt_pkg::ST_LOOKUP: begin
            mem_we = lookup_fire;
         end
         default: begin
            status.clearing = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlctt_pkg::ST_CLEAR;
         clear_idx_ff <= '0;
         l1_miss_ff   <= '0;
         l2_miss_ff   <= '0;
         ref_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         l1_miss_ff   <= l1_miss_in;
         l2_miss_ff   <= l2_miss_in;
         ref_ff       <= ref_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_fire) begin
         cur_ff <= q_item;
      end
      if (lookup_fire) begin
         out_ff.l1_hit          <= l1_hit;
         out_ff.l2_hit          <= !l1_hit && l2_hit;
         out_ff.l1_miss_total   <= l1_miss_in;
         out_ff.l2_miss_total   <= l2_miss_in;
         out_ff.reference_total <= ref_in;
      end
   end

   // set memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= set_mem[q_item.set_idx];
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

@@ sv/two_level_cache_tag_tracker_unit.sv @@
// top level of the two-level cache tag tracker
// depends on tlctt_pkg, tlctt_front and tlctt_back
`timescale 1ns / 1ps

//  channel   handshake            payload
//  req       req_valid/req_ready  req_address[31:0]
//  rsp       rsp_valid/rsp_ready  rsp_l1_hit, rsp_l2_hit, rsp_l1_miss_total,
//                                 rsp_l2_miss_total, rsp_reference_total
//
// each back-end item: a fetch step reads its set from the set memory, then an
// update step updates the set, writes it back and loads the result register
// a two-entry queue takes items while the back end is busy
// after reset all 16384 sets are cleared; req_ready stays low meanwhile
// a stalled rsp holds the back end in its update step; items queue behind it

module two_level_cache_tag_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_l1_hit,
   output logic        rsp_l2_hit,
   output logic [31:0] rsp_l1_miss_total,
   output logic [31:0] rsp_l2_miss_total,
   output logic [31:0] rsp_reference_total
);

   tlctt_pkg::tlctt_status_type status;
   logic                        q_valid;
   tlctt_pkg::tlctt_item_type   q_item;
   tlctt_pkg::tlctt_result_type result;

   tlctt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .status      (status),
      .q_valid     (q_valid),
      .q_item      (q_item)
   );

   tlctt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_l1_hit          = result.l1_hit;
   assign rsp_l2_hit          = result.l2_hit;
   assign rsp_l1_miss_total   = result.l1_miss_total;
   assign rsp_l2_miss_total   = result.l2_miss_total;
   assign rsp_reference_total = result.reference_total;

   a_no_intake_while_clearing : assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req_ready)
      else $error("item taken during set memory sweep");

   a_hit_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_l1_hit && rsp_l2_hit))
      else $error("l1 and l2 hit flagged together");

   a_totals_ordered : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_l2_miss_total <= rsp_l1_miss_total)
                    && (rsp_l1_miss_total <= rsp_reference_total))
      else $error("running totals out of order");

   a_next_item_counts : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid
         || (rsp_reference_total != $past(rsp_reference_total))
         || ($past(rsp_reference_total) == 32'hFFFF_FFFF))
      else $error("result repeated after it was taken");

endmodule
